[rtl/bbhg_pkg.sv]
// Package with shared types and constants for the boot button hold gesture detector.
`default_nettype none

package bbhg_pkg;

	// Widths of the timestamp, the count and the configuration port.
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 32;

	// Reset values of the hold time registers.
	localparam logic [TIME_W-1:0] PROV_HOLD_RESET    = 32'd5000;
	localparam logic [TIME_W-1:0] REQUEST_HOLD_RESET = 32'd10000;
	localparam logic [TIME_W-1:0] CONFIRM_HOLD_RESET = 32'd5000;

	// Operating modes of the detector.
	typedef enum logic [1:0] {
		MODE_COMBOS  = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_CONFIRM = 2'd2
	} mode_t;

	// Button combination that is being timed.
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_AB   = 2'd1,
		KIND_ABC  = 2'd2
	} kind_t;

	// Gesture codes carried in each result.
	typedef enum logic [1:0] {
		G_NONE    = 2'd0,
		G_PROV    = 2'd1,
		G_REQUEST = 2'd2,
		G_FACTORY = 2'd3
	} gesture_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PROV_HOLD    = 8'd0,
		REG_REQUEST_HOLD = 8'd1,
		REG_CONFIRM_HOLD = 8'd2,
		REG_PENDING      = 8'd3
	} reg_index_t;

endpackage

`default_nettype wire

[rtl/boot_button_hold_gesture_detector.sv]
// Top level of the boot button hold gesture detector.
`default_nettype none

// Takes one sample of buttons A, B and C with a millisecond timestamp per transfer and
// returns one result per sample. Holding A and B alone for provisioning_hold_ms gives a
// provisioning gesture once per hold; holding all three for factory_request_hold_ms gives a
// factory reset request, after which all buttons must be released and C alone held for
// factory_confirm_hold_ms to give the factory reset. Hold times are measured by wrapping
// 32-bit subtraction of timestamps. A sample is taken into an input register, evaluated
// against the gesture state, and its result is placed in an output register, so the block
// accepts one sample per cycle while the output is not stalled. Configuration writes are
// always ready and take effect on the next sample; indexes beyond 3 are ignored.
module boot_button_hold_gesture_detector
	import bbhg_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration write channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// Sample channel.
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   button_a,
	input  wire logic                   button_b,
	input  wire logic                   button_c,
	input  wire logic [TIME_W-1:0]      elapsed_ms,
	// Result channel.
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [1:0]                  gesture,
	output logic [COUNT_W-1:0]          gesture_count,
	output logic                        awaiting_confirmation
);

	// Configuration registers.
	logic [TIME_W-1:0]  prov_hold_q;
	logic [TIME_W-1:0]  request_hold_q;
	logic [TIME_W-1:0]  confirm_hold_q;
	logic [COUNT_W-1:0] pending_q;

	// Input stage.
	logic              valid_s1;
	logic              a_s1;
	logic              b_s1;
	logic              c_s1;
	logic [TIME_W-1:0] now_s1;

	// Result stage.
	logic               valid_s2;
	gesture_t           gesture_s2;
	logic [COUNT_W-1:0] count_s2;
	logic               awaiting_s2;

	// Gesture state.
	mode_t             mode_q, mode_d;
	logic              combo_timing_q, combo_timing_d;
	kind_t             combo_kind_q, combo_kind_d;
	logic [TIME_W-1:0] combo_start_q, combo_start_d;
	logic              prov_sent_q, prov_sent_d;
	logic              confirm_timing_q, confirm_timing_d;
	logic [TIME_W-1:0] confirm_start_q, confirm_start_d;

	// Evaluation signals.
	logic              advance;
	logic              pat_none, pat_c, pat_ab, pat_abc;
	logic              ab_timed, abc_timed;
	logic [TIME_W-1:0] combo_span, confirm_span;
	logic              prov_due, request_due, confirm_due;
	gesture_t          gesture_d;

	// Handshakes: the input stage moves whenever the result register is free or drained.
	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prov_hold_q    <= PROV_HOLD_RESET;
			request_hold_q <= REQUEST_HOLD_RESET;
			confirm_hold_q <= CONFIRM_HOLD_RESET;
			pending_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PROV_HOLD:    prov_hold_q    <= cfg_data;
				REG_REQUEST_HOLD: request_hold_q <= cfg_data;
				REG_CONFIRM_HOLD: confirm_hold_q <= cfg_data;
				REG_PENDING:      pending_q      <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			a_s1   <= button_a;
			b_s1   <= button_b;
			c_s1   <= button_c;
			now_s1 <= elapsed_ms;
		end
	end

	// Button patterns and hold comparisons of the sample in the input register.
	assign pat_none  = !a_s1 && !b_s1 && !c_s1;
	assign pat_c     = !a_s1 && !b_s1 && c_s1;
	assign pat_ab    = a_s1 && b_s1 && !c_s1;
	assign pat_abc   = a_s1 && b_s1 && c_s1;
	assign ab_timed  = combo_timing_q && (combo_kind_q == KIND_AB);
	assign abc_timed = combo_timing_q && (combo_kind_q == KIND_ABC);

	assign combo_span   = now_s1 - combo_start_q;
	assign confirm_span = now_s1 - confirm_start_q;

	assign prov_due    = ab_timed && !prov_sent_q && (combo_span >= prov_hold_q);
	assign request_due = abc_timed && (combo_span >= request_hold_q);
	assign confirm_due = confirm_timing_q && (confirm_span >= confirm_hold_q);

	// Next state of the gesture logic.
	always_comb begin
		mode_d           = mode_q;
		combo_timing_d   = combo_timing_q;
		combo_kind_d     = combo_kind_q;
		combo_start_d    = combo_start_q;
		prov_sent_d      = prov_sent_q;
		confirm_timing_d = confirm_timing_q;
		confirm_start_d  = confirm_start_q;
		unique case (mode_q)
			MODE_RELEASE: begin
				if (pat_none) begin
					mode_d           = MODE_CONFIRM;
					confirm_timing_d = 1'b0;
					confirm_start_d  = '0;
				end
			end
			MODE_CONFIRM: begin
				if (!pat_c) begin
					confirm_timing_d = 1'b0;
					confirm_start_d  = '0;
				end else if (!confirm_timing_q) begin
					confirm_timing_d = 1'b1;
					confirm_start_d  = now_s1;
				end else if (confirm_due) begin
					mode_d           = MODE_RELEASE;
					confirm_timing_d = 1'b0;
					confirm_start_d  = '0;
				end
			end
			default: begin
				// Boot combos mode; the unused code behaves the same way.
				mode_d = MODE_COMBOS;
				if (pat_abc) begin
					prov_sent_d = 1'b0;
					if (!abc_timed) begin
						combo_timing_d = 1'b1;
						combo_kind_d   = KIND_ABC;
						combo_start_d  = now_s1;
					end else if (request_due) begin
						mode_d         = MODE_RELEASE;
						combo_timing_d = 1'b0;
						combo_kind_d   = KIND_NONE;
						combo_start_d  = '0;
					end
				end else if (pat_ab) begin
					if (!ab_timed) begin
						combo_timing_d = 1'b1;
						combo_kind_d   = KIND_AB;
						combo_start_d  = now_s1;
						prov_sent_d    = 1'b0;
					end else if (prov_due) begin
						prov_sent_d = 1'b1;
					end
				end else begin
					combo_timing_d = 1'b0;
					combo_kind_d   = KIND_NONE;
					combo_start_d  = '0;
					prov_sent_d    = 1'b0;
				end
			end
		endcase
	end

	// Gesture emitted by the sample in the input register.
	always_comb begin
		gesture_d = G_NONE;
		unique case (mode_q)
			MODE_RELEASE: begin
				gesture_d = G_NONE;
			end
			MODE_CONFIRM: begin
				if (pat_c && confirm_due) begin
					gesture_d = G_FACTORY;
				end
			end
			default: begin
				if (pat_abc && request_due) begin
					gesture_d = G_REQUEST;
				end else if (pat_ab && prov_due) begin
					gesture_d = G_PROV;
				end
			end
		endcase
	end

	// Gesture state registers, updated once per evaluated sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_COMBOS;
			combo_timing_q   <= 1'b0;
			combo_kind_q     <= KIND_NONE;
			combo_start_q    <= '0;
			prov_sent_q      <= 1'b0;
			confirm_timing_q <= 1'b0;
			confirm_start_q  <= '0;
		end else if (advance) begin
			mode_q           <= mode_d;
			combo_timing_q   <= combo_timing_d;
			combo_kind_q     <= combo_kind_d;
			combo_start_q    <= combo_start_d;
			prov_sent_q      <= prov_sent_d;
			confirm_timing_q <= confirm_timing_d;
			confirm_start_q  <= confirm_start_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_s2  <= gesture_d;
			count_s2    <= (gesture_d != G_NONE) ? pending_q : '0;
			awaiting_s2 <= (mode_d != MODE_COMBOS);
		end
	end

	assign out_valid             = valid_s2;
	assign gesture               = gesture_s2;
	assign gesture_count         = count_s2;
	assign awaiting_confirmation = awaiting_s2;

`ifndef SYNTH
	// Combo timing is only kept while in boot combos mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_COMBOS) |-> !combo_timing_q)
		else $error("combo timing active outside boot combos mode");

	// Confirm timing is only kept while in confirm mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		confirm_timing_q |-> (mode_q == MODE_CONFIRM))
		else $error("confirm timing active outside confirm mode");

	// A factory reset request always leaves the block waiting for confirmation.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (gesture == G_REQUEST)) |-> awaiting_confirmation)
		else $error("factory reset request without confirmation mode");

	// A provisioning gesture is only given in boot combos mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (gesture == G_PROV)) |-> !awaiting_confirmation)
		else $error("provisioning gesture while awaiting confirmation");

	// An evaluated sample always reaches the result register on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("evaluated sample lost before the result register");
`endif

endmodule

`default_nettype wire
